[sv/nudtb_pkg.sv]
// nudtb_pkg: shared types, codes and the per-slot count update of the timer bank
// no dependencies
`default_nettype none

package nudtb_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] TPS_RESET = 16'd24;
  localparam logic signed [31:0] VALUE_NONE = -32'sd1;
  localparam logic REG_TPS = 1'b0;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_ZERO_ID   = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] number;
    logic [30:0] tick;
    logic [30:0] sec;
    logic        up;
    logic        frame;
  } entry_t;

  typedef struct packed {
    logic [30:0] tick;
    logic [30:0] sec;
  } count_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

  function automatic count_t advance(count_t c, logic up, logic frame, logic [15:0] tps);
    count_t      r;
    logic [30:0] t_inc;
    logic [30:0] s_inc;
    r     = c;
    t_inc = (c.tick == COUNT_MAX) ? COUNT_MAX : c.tick + 31'd1;
    s_inc = (c.sec == COUNT_MAX) ? COUNT_MAX : c.sec + 31'd1;
    if (frame) begin
      if (up) begin
        r.tick = t_inc;
      end else if (c.tick != 31'd0) begin
        r.tick = c.tick - 31'd1;
      end
    end else if (up) begin
      if (t_inc >= {15'd0, tps}) begin
        r.tick = 31'd0;
        r.sec  = s_inc;
      end else begin
        r.tick = t_inc;
      end
    end else if (c.tick == 31'd0) begin
      r.tick = {15'd0, tps};
      if (c.sec != 31'd0) begin
        r.sec = c.sec - 31'd1;
      end
    end else begin
      r.tick = c.tick - 31'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/numbered_up_down_timer_bank_unit.sv]
// numbered_up_down_timer_bank_unit: top level of the numbered timer bank
// depends on nudtb_pkg, nudtb_ctrl, nudtb_dp and nudtb_ram
`default_nettype none

// A bank of NUM_SLOTS timers looked up by a nonzero 16-bit number. An item is
// taken when start_i is high and busy_o low; its one result appears on value_o
// and status_o with done_o high for a single cycle, and cannot be held off.
// Tick, start and read walk every slot through the single read port of the slot
// ram before busy_o falls with the result; clear, and start or read with a zero id,
// skip the walk.
// ticks_per_second sits at byte address 0 of the apb port and resets to 24.
module numbered_up_down_timer_bank_unit
  import nudtb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [15:0]        timer_id_i,
  input  wire logic [30:0]        start_value_i,
  input  wire logic               count_up_i,
  input  wire logic               frame_mode_i,
  output logic                    done_o,
  output logic signed [31:0]      value_o,
  output logic [1:0]              status_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] tps_q;
  dp_cmd_t     dp_cmd;
  dp_sts_t     dp_sts;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_TPS);
  assign prdata  = reg_hit ? {16'd0, tps_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tps_q <= pwdata[15:0];
    end
  end

  nudtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .command_i  (command_i),
    .timer_id_i (timer_id_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd),
    .busy_o     (busy_o)
  );

  nudtb_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .command_i     (command_i),
    .timer_id_i    (timer_id_i),
    .start_value_i (start_value_i),
    .count_up_i    (count_up_i),
    .frame_mode_i  (frame_mode_i),
    .tps_i         (tps_q),
    .done_o        (done_o),
    .value_o       (value_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

[sv/nudtb_ram.sv]
// nudtb_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module nudtb_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/nudtb_ctrl.sv]
// nudtb_ctrl: command sequencer of the timer bank
// depends on nudtb_pkg
`default_nettype none

module nudtb_ctrl
  import nudtb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] command_i,
  input  wire logic [15:0] timer_id_i,
  input  wire dp_sts_t    sts_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd_in;
  logic   skip;

  assign cmd_in = cmd_e'(command_i);
  assign skip   = (cmd_in == CMD_CLEAR) || ((cmd_in != CMD_TICK) && (timer_id_i == 16'd0));

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = skip ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_finish_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> (state_q == S_IDLE))
    else $error("finish not followed by idle");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without an accepted item");

  a_scan_needs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && !skip) |=> (state_q == S_SCAN))
    else $error("walk not entered after load");

endmodule

`default_nettype wire

[sv/nudtb_dp.sv]
// nudtb_dp: slot walk, count update, slot allocation and result registers
// depends on nudtb_pkg and nudtb_ram
`default_nettype none

module nudtb_dp
  import nudtb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16,
  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] timer_id_i,
  input  wire logic [30:0] start_value_i,
  input  wire logic        count_up_i,
  input  wire logic        frame_mode_i,
  input  wire logic [15:0] tps_i,
  output logic             done_o,
  output logic signed [31:0] value_o,
  output logic [1:0]       status_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  cmd_e             cmd_q;
  logic [15:0]      id_q;
  logic [30:0]      sval_q;
  logic             up_q;
  logic             frame_q;
  logic             iss_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             pv_q;
  logic [IDX_W-1:0] pl_idx_q;
  logic [NUM_SLOTS-1:0] valid_q;
  logic             found_q;
  logic [IDX_W-1:0] found_idx_q;
  logic [30:0]      found_val_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;

  entry_t           rd_entry;
  entry_t           wr_entry;
  count_t           adv;
  logic             ram_re;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             tick_wb;
  logic             start_wr;
  logic             slot_live;
  logic             hit;
  logic signed [31:0] value_d;
  status_e          status_d;

  nudtb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_entry)
  );

  assign ram_re    = cmd_i.scan && iss_q;
  assign slot_live = valid_q[pl_idx_q];
  assign hit       = pv_q && slot_live && (rd_entry.number == id_q);
  assign adv       = advance('{tick: rd_entry.tick, sec: rd_entry.sec},
                             rd_entry.up, rd_entry.frame, tps_i);
  assign tick_wb   = pv_q && (cmd_q == CMD_TICK) && slot_live;
  assign start_wr  = cmd_i.finish && (cmd_q == CMD_START) && (id_q != 16'd0)
                     && (found_q || free_q);
  assign ram_we    = tick_wb || start_wr;
  assign ram_waddr = tick_wb ? pl_idx_q : (found_q ? found_idx_q : free_idx_q);

  always_comb begin
    if (tick_wb) begin
      wr_entry = '{number: rd_entry.number, tick: adv.tick, sec: adv.sec,
                   up: rd_entry.up, frame: rd_entry.frame};
    end else begin
      wr_entry = '{number: id_q, tick: frame_q ? sval_q : 31'd0,
                   sec: frame_q ? 31'd0 : sval_q, up: up_q, frame: frame_q};
    end
  end

  assign sts_o.scan_done = pv_q && (pl_idx_q == LAST_IDX);

  always_comb begin
    value_d  = '0;
    status_d = ST_OK;
    case (cmd_q)
      CMD_START: begin
        if (id_q == 16'd0) begin
          status_d = ST_ZERO_ID;
        end else if (!found_q && !free_q) begin
          status_d = ST_NO_FREE;
        end
      end
      CMD_READ: begin
        if (id_q == 16'd0) begin
          status_d = ST_ZERO_ID;
        end else if (found_q) begin
          value_d = $signed({1'b0, found_val_q});
        end else begin
          value_d  = VALUE_NONE;
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cmd_e'(command_i);
      id_q    <= timer_id_i;
      sval_q  <= start_value_i;
      up_q    <= count_up_i;
      frame_q <= frame_mode_i;
    end
    if (ram_re) begin
      pl_idx_q <= rd_idx_q;
    end
    if (hit && !found_q) begin
      found_idx_q <= pl_idx_q;
      found_val_q <= rd_entry.frame ? rd_entry.tick : rd_entry.sec;
    end
    if (pv_q && !slot_live && !free_q) begin
      free_idx_q <= pl_idx_q;
    end
    if (cmd_i.finish) begin
      value_o  <= value_d;
      status_o <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q    <= 1'b0;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
      valid_q  <= '0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      pv_q   <= ram_re;
      if (cmd_i.load) begin
        iss_q    <= 1'b1;
        rd_idx_q <= '0;
        found_q  <= 1'b0;
        free_q   <= 1'b0;
      end else if (ram_re) begin
        if (rd_idx_q == LAST_IDX) begin
          iss_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
        end
      end
      if (hit) begin
        found_q <= 1'b1;
      end
      if (pv_q && !slot_live) begin
        free_q <= 1'b1;
      end
      if (cmd_i.finish && (cmd_q == CMD_CLEAR)) begin
        valid_q <= '0;
      end else if (start_wr) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_i.finish))
    else $error("result strobe without finish");

  a_found_is_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (cmd_q == CMD_START) && found_q) |-> valid_q[found_idx_q])
    else $error("matched slot not live");

  a_free_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (cmd_q == CMD_START) && free_q) |-> !valid_q[free_idx_q])
    else $error("allocated slot already live");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// tb_top: self-checking testbench for numbered_up_down_timer_bank_unit
// drives commands and the apb register port, predicts every reply in-house
// depends on nudtb_pkg and the numbered_up_down_timer_bank_unit rtl
`default_nettype none

module tb_top
  import nudtb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = 16;
  localparam logic [31:0] COUNT_TOP = {1'b0, COUNT_MAX};
  localparam logic [PADDR_W-1:0] TPS_ADDR = {REG_TPS, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_TPS, 2'b00};

  typedef struct {
    logic [31:0] value;
    status_e     status;
  } reading_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [1:0]         command_i = CMD_TICK;
  logic [15:0]        timer_id_i = '0;
  logic [30:0]        start_value_i = '0;
  logic               count_up_i = 1'b0;
  logic               frame_mode_i = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic               busy_o;
  logic               done_o;
  logic signed [31:0] value_o;
  logic [1:0]         status_o;
  logic [31:0]        prdata;
  logic               pready;

  logic [15:0] slot_num [NSLOT];
  logic [31:0] slot_ticks [NSLOT];
  logic [31:0] slot_secs [NSLOT];
  logic        slot_up [NSLOT];
  logic        slot_frame [NSLOT];
  logic [15:0] tps_model = TPS_RESET;

  reading_t    pending_readings [$];
  int unsigned mismatch_count = 0;

  numbered_up_down_timer_bank_unit #(
    .NUM_SLOTS(NSLOT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .timer_id_i   (timer_id_i),
    .start_value_i(start_value_i),
    .count_up_i   (count_up_i),
    .frame_mode_i (frame_mode_i),
    .done_o       (done_o),
    .value_o      (value_o),
    .status_o     (status_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v >= COUNT_TOP) ? COUNT_TOP : v + 32'd1;
  endfunction

  function automatic int find_slot(logic [15:0] id);
    for (int s = 0; s < NSLOT; s++) begin
      if (slot_num[s] == id) begin
        return s;
      end
    end
    return -1;
  endfunction

  function automatic void tick_slot(int s);
    if (slot_frame[s]) begin
      if (slot_up[s]) begin
        slot_ticks[s] = sat_inc(slot_ticks[s]);
      end else if (slot_ticks[s] != 0) begin
        slot_ticks[s] = slot_ticks[s] - 32'd1;
      end
    end else if (slot_up[s]) begin
      slot_ticks[s] = sat_inc(slot_ticks[s]);
      if (slot_ticks[s] >= {16'd0, tps_model}) begin
        slot_ticks[s] = '0;
        slot_secs[s] = sat_inc(slot_secs[s]);
      end
    end else if (slot_ticks[s] == 0) begin
      slot_ticks[s] = {16'd0, tps_model};
      if (slot_secs[s] != 0) begin
        slot_secs[s] = slot_secs[s] - 32'd1;
      end
    end else begin
      slot_ticks[s] = slot_ticks[s] - 32'd1;
    end
  endfunction

  // applies one command to the bank copy and returns the reply it gives
  function automatic reading_t bank_reply(cmd_e cmd, logic [15:0] id, logic [30:0] init,
                                          logic up, logic frame);
    reading_t r;
    int       s;
    r.value = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_TICK: begin
        for (s = 0; s < NSLOT; s++) begin
          if (slot_num[s] != 0) begin
            tick_slot(s);
          end
        end
      end
      CMD_CLEAR: begin
        for (s = 0; s < NSLOT; s++) begin
          slot_num[s] = '0;
          slot_ticks[s] = '0;
          slot_secs[s] = '0;
          slot_up[s] = 1'b0;
          slot_frame[s] = 1'b0;
        end
      end
      default: begin
        if (id == 0) begin
          r.status = ST_ZERO_ID;
        end else if (cmd == CMD_START) begin
          s = find_slot(id);
          if (s < 0) begin
            s = find_slot(16'd0);
          end
          if (s < 0) begin
            r.status = ST_NO_FREE;
          end else begin
            slot_num[s] = id;
            slot_up[s] = up;
            slot_frame[s] = frame;
            slot_ticks[s] = frame ? {1'b0, init} : 32'd0;
            slot_secs[s] = frame ? 32'd0 : {1'b0, init};
          end
        end else begin
          s = find_slot(id);
          if (s < 0) begin
            r.value = VALUE_NONE;
            r.status = ST_NOT_FOUND;
          end else begin
            r.value = slot_frame[s] ? slot_ticks[s] : slot_secs[s];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && done_o) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reply with no item outstanding", value_o, '0);
      end else begin
        want = pending_readings.pop_front();
        if (value_o !== want.value) begin
          report_mismatch("value", value_o, want.value);
        end
        if (status_o !== want.status) begin
          report_mismatch("status", {30'd0, status_o}, {30'd0, want.status});
        end
      end
    end
  end

  // start stays high after acceptance; whatever follows sets or lowers it
  task automatic send_item(cmd_e cmd, logic [15:0] id, logic [30:0] init, logic up,
                           logic frame);
    start_i <= 1'b1;
    command_i <= cmd;
    timer_id_i <= id;
    start_value_i <= init;
    count_up_i <= up;
    frame_mode_i <= frame;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_readings.push_back(bank_reply(cmd, id, init, up, frame));
  endtask

  task automatic sender_gap(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (NSLOT + 4) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_tps(logic [PADDR_W-1:0] addr, logic [31:0] data);
    logic [31:0] rdata;
    wait_idle();
    apb_access(1'b1, addr, data, rdata);
    if (addr == TPS_ADDR) begin
      tps_model = data[15:0];
    end
    apb_access(1'b0, TPS_ADDR, '0, rdata);
    if (rdata !== {16'd0, tps_model}) begin
      report_mismatch("ticks_per_second readback", rdata, {16'd0, tps_model});
    end
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(99) < 85) ? 16'($urandom_range(1, 20))
                                     : 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [30:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      return 31'($urandom_range(0, 30));
    end else if (roll < 60) begin
      return COUNT_MAX - 31'($urandom_range(0, 3));
    end else if (roll < 80) begin
      return 31'($urandom_range(0, 100));
    end
    return 31'($urandom);
  endfunction

  task automatic test_zero_id();
    send_item(CMD_START, 16'd0, COUNT_MAX, 1'b1, 1'b1);
    send_item(CMD_READ, 16'd0, COUNT_MAX, 1'b1, 1'b1);
  endtask

  // fills every slot, the first four with corner counts, then tries one more number and restarts number 1
  task automatic test_fill_bank();
    for (int i = 0; i < NSLOT; i++) begin
      case (i)
        0: send_item(CMD_START, 16'd1, COUNT_MAX - 31'd1, 1'b1, 1'b1);
        1: send_item(CMD_START, 16'd4100, COUNT_MAX, 1'b1, 1'b0);
        2: send_item(CMD_START, 16'd8199, 31'd0, 1'b0, 1'b1);
        3: send_item(CMD_START, 16'd12298, 31'd1, 1'b0, 1'b0);
        NSLOT - 1: send_item(CMD_START, 16'hFFFF, 31'($urandom_range(0, 40)), 1'b0, 1'b0);
        default: send_item(CMD_START, 16'(i * 4099 + 1), 31'($urandom_range(0, 40)),
                           1'($urandom), 1'($urandom));
      endcase
    end
    send_item(CMD_START, 16'h7FFE, 31'd5, 1'b1, 1'b1);
    send_item(CMD_START, 16'd1, COUNT_MAX - 31'd1, 1'b1, 1'b1);
  endtask

  // saturation, zero register and a register lowered under a running count
  task automatic test_tick_and_register();
    send_item(CMD_TICK, 16'd0, '0, 1'b0, 1'b0);
    write_tps(TPS_ADDR, 32'd0);
    send_item(CMD_TICK, 16'hFFFF, COUNT_MAX, 1'b1, 1'b1);
    write_tps(TPS_ADDR, 32'd1);
    write_tps(SPARE_ADDR, 32'd9);
    send_item(CMD_TICK, 16'd0, '0, 1'b0, 1'b0);
    send_item(CMD_READ, 16'd1, '0, 1'b0, 1'b0);
    send_item(CMD_READ, 16'd4100, '0, 1'b0, 1'b0);
    send_item(CMD_READ, 16'd12298, '0, 1'b0, 1'b0);
  endtask

  task automatic test_clear();
    send_item(CMD_CLEAR, 16'hFFFF, COUNT_MAX, 1'b1, 1'b1);
    send_item(CMD_READ, 16'd1, '0, 1'b0, 1'b0);
  endtask

  task automatic test_random_mix(int unsigned n, int unsigned idle_pct, logic [15:0] tps);
    int unsigned roll;
    write_tps(TPS_ADDR, {16'($urandom), tps});
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < idle_pct) begin
        sender_gap($urandom_range(1, 24));
      end
      roll = $urandom_range(99);
      if (roll < 38) begin
        send_item(CMD_TICK, 16'($urandom), 31'($urandom), 1'($urandom), 1'($urandom));
      end else if (roll < 62) begin
        send_item(CMD_START, pick_id(), pick_count(), 1'($urandom), 1'($urandom));
      end else if (roll < 90) begin
        send_item(CMD_READ, pick_id(), 31'($urandom), 1'($urandom), 1'($urandom));
      end else if (roll < 92) begin
        send_item(CMD_CLEAR, 16'($urandom), 31'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_item(roll[0] ? CMD_START : CMD_READ, 16'd0, 31'($urandom), 1'($urandom),
                  1'($urandom));
      end
    end
  endtask

  initial begin
    void'(bank_reply(CMD_CLEAR, '0, '0, 1'b0, 1'b0));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_id();
    test_fill_bank();
    test_tick_and_register();
    test_clear();
    test_random_mix(190, 0, 16'd24);
    test_random_mix(190, 50, 16'd1);
    test_random_mix(190, 18, 16'd0);
    test_random_mix(190, 0, 16'hFFFF);
    test_random_mix(190, 50, 16'd3);
    test_random_mix(190, 18, 16'($urandom_range(2, 100)));
    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
